// ===== rtl/pprm_pkg.sv =====
// shared types and constants for the perspective pixel remap block
// no dependencies

package pprm_pkg;

   localparam int COEF_W   = 32;
   localparam int COORD_W  = 7;
   localparam int SUM_W    = 42;
   localparam int DIV_W    = 52;
   localparam int QUO_W    = 8;
   localparam int IDX_W    = 15;
   localparam int PIX_W    = 8;
   localparam int STAT_W   = 2;
   localparam int CSR_IDX_W = 4;

   localparam logic [PIX_W-1:0] GRAY_WHITE = 8'd254;
   localparam logic [PIX_W-1:0] GRAY_BLACK = 8'd0;

   localparam logic [STAT_W-1:0] ST_WRITE   = 2'd0;
   localparam logic [STAT_W-1:0] ST_OUTSIDE = 2'd1;
   localparam logic [STAT_W-1:0] ST_SCALE   = 2'd2;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_M00 = 4'd0, REG_M01 = 4'd1, REG_M02 = 4'd2, REG_M10 = 4'd3,
      REG_M11 = 4'd4, REG_M12 = 4'd5, REG_M20 = 4'd6, REG_M21 = 4'd7
   } reg_idx_type;

   // class of one coordinate before the quotient digits are known
   typedef enum logic [1:0] {
      CLS_ZERO = 2'd0,
      CLS_POS  = 2'd1,
      CLS_BAD  = 2'd2
   } cls_type;

   typedef struct packed {
      logic               valid;
      logic [DIV_W-1:0]   rem_u;
      logic [DIV_W-1:0]   rem_v;
      logic [QUO_W-1:0]   q_u;
      logic [QUO_W-1:0]   q_v;
      logic [DIV_W-1:0]   den;
      cls_type            cls_u;
      cls_type            cls_v;
      logic               bad_scale;
      logic [PIX_W-1:0]   pix;
   } div_stage_type;

endpackage

// ===== rtl/perspective_pixel_remap_top.sv =====
// perspective pixel remap: matrix products, sums, ceiling divide, address
// depends on pprm_pkg
//
// usage: one source pixel enters per item on req_ (tdata = column, row,
// pixel). the block forms u, v and s from the eight signed Q8.24 matrix
// registers, takes ceil(u/s) and ceil(v/s) and returns one item on rsp_
// with destination column, row, linear address and gray level; tuser is
// the status (0 write, 1 outside frame, 2 non-positive scale).
// throughput: one item per cycle while rsp_tready keeps up (a stall holds
// the pipeline); the quotient is built one bit per stage over eight stages.
// the csr_ channel writes register csr_index with csr_data, always ready;
// write it only while the pipeline is empty.
// reset clears all stage valid bits and loads the identity matrix.
// when the receiver stalls the whole pipeline holds, req_tready drops,
// and nothing is lost or repeated.

module perspective_pixel_remap_top
   import pprm_pkg::*;
#(
   parameter int SRC_WIDTH      = 128,
   parameter int SRC_HEIGHT     = 128,
   parameter int MARGIN_X       = 30,
   parameter int MARGIN_Y       = 30,
   parameter int COEF_FRAC_BITS = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [15:0]          req_tdata,   // src_col[6:0], src_row[13:7], src_pixel[14]
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [39:0]          rsp_tdata,   // dst_col[7:0], dst_row[15:8],
                                              // dst_index[30:16], pixel_value[38:31]
   output logic [STAT_W-1:0]    rsp_tuser,   // status[1:0]
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COEF_W-1:0]    csr_data
);

   localparam int PAD_W = SRC_WIDTH + MARGIN_X;
   localparam int PAD_H = SRC_HEIGHT + MARGIN_Y;
   localparam logic [QUO_W:0]  PAD_W_Q = (QUO_W+1)'(PAD_W);
   localparam logic [QUO_W:0]  PAD_H_Q = (QUO_W+1)'(PAD_H);
   localparam logic [IDX_W-1:0] PAD_W_I = IDX_W'(PAD_W);
   localparam logic signed [SUM_W-1:0] ONE_S = SUM_W'(64'sd1 <<< COEF_FRAC_BITS);
   localparam int NSTG = QUO_W;
   localparam int PROD_W = COEF_W + COORD_W + 1;

   logic signed [COEF_W-1:0] m_ff [8];
   logic advance;
   logic dv_out_valid_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) m_ff[i] <= '0;
         m_ff[3'(REG_M00)] <= COEF_W'(64'sd1 <<< COEF_FRAC_BITS);
         m_ff[3'(REG_M11)] <= COEF_W'(64'sd1 <<< COEF_FRAC_BITS);
      end else if (csr_valid && csr_index < CSR_IDX_W'(8)) begin
         m_ff[csr_index[2:0]] <= csr_data;
      end
   end

   // stage 1: products
   logic                        s1_valid_ff;
   logic signed [PROD_W-1:0]    p_ff [6];
   logic [PIX_W-1:0]            s1_pix_ff;
   logic signed [COORD_W:0]     col_s, row_s;

   assign col_s = $signed({1'b0, req_tdata[6:0]});
   assign row_s = $signed({1'b0, req_tdata[13:7]});
   assign rsp_tvalid = dv_out_valid_ff;

   assign advance    = !dv_out_valid_ff || rsp_tready;
   assign req_tready = advance;

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else if (advance) s1_valid_ff <= req_tvalid;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p_ff[0]   <= PROD_W'(m_ff[3'(REG_M00)]) * PROD_W'(col_s);
         p_ff[1]   <= PROD_W'(m_ff[3'(REG_M01)]) * PROD_W'(row_s);
         p_ff[2]   <= PROD_W'(m_ff[3'(REG_M10)]) * PROD_W'(col_s);
         p_ff[3]   <= PROD_W'(m_ff[3'(REG_M11)]) * PROD_W'(row_s);
         p_ff[4]   <= PROD_W'(m_ff[3'(REG_M20)]) * PROD_W'(col_s);
         p_ff[5]   <= PROD_W'(m_ff[3'(REG_M21)]) * PROD_W'(row_s);
         s1_pix_ff <= req_tdata[14] ? GRAY_BLACK : GRAY_WHITE;
      end
   end

   // stage 2: sums
   logic                     s2_valid_ff;
   logic signed [SUM_W-1:0]  u_ff, v_ff, s_ff;
   logic [PIX_W-1:0]         s2_pix_ff;

   always_ff @(posedge clock) begin
      if (reset) s2_valid_ff <= 1'b0;
      else if (advance) s2_valid_ff <= s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         u_ff <= SUM_W'(p_ff[0]) + SUM_W'(p_ff[1]) + SUM_W'(m_ff[3'(REG_M02)]);
         v_ff <= SUM_W'(p_ff[2]) + SUM_W'(p_ff[3]) + SUM_W'(m_ff[3'(REG_M12)]);
         s_ff <= SUM_W'(p_ff[4]) + SUM_W'(p_ff[5]) + ONE_S;
         s2_pix_ff <= s1_pix_ff;
      end
   end

   // stage 3: classify and set up numerators
   div_stage_type dv_ff [NSTG+1];
   div_stage_type dv_in;
   logic signed [DIV_W-1:0] den_w, u_w, v_w, lim_w;

   function automatic cls_type classify(input logic signed [DIV_W-1:0] n,
                                        input logic signed [DIV_W-1:0] d,
                                        input logic signed [DIV_W-1:0] lim);
      cls_type c;
      if (n <= 0) c = (n + d > 0) ? CLS_ZERO : CLS_BAD;
      else        c = (n - 1 >= lim) ? CLS_BAD : CLS_POS;
      return c;
   endfunction

   always_comb begin
      den_w = DIV_W'(s_ff);
      u_w   = DIV_W'(u_ff);
      v_w   = DIV_W'(v_ff);
      lim_w = den_w <<< QUO_W;
      dv_in.valid     = s2_valid_ff;
      dv_in.bad_scale = (s_ff <= 0);
      dv_in.den       = dv_in.bad_scale ? DIV_W'(1) : den_w;
      dv_in.cls_u     = classify(u_w, den_w, lim_w);
      dv_in.cls_v     = classify(v_w, den_w, lim_w);
      dv_in.rem_u     = (dv_in.cls_u == CLS_POS) ? u_w - 1 : '0;
      dv_in.rem_v     = (dv_in.cls_v == CLS_POS) ? v_w - 1 : '0;
      dv_in.q_u       = '0;
      dv_in.q_v       = '0;
      dv_in.pix       = s2_pix_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) dv_ff[0].valid <= 1'b0;
      else if (advance) dv_ff[0] <= dv_in;
   end

   // restoring divide, one quotient bit per stage, msb first
   for (genvar k = 0; k < NSTG; k++) begin : g_div
      localparam int SH = NSTG - 1 - k;
      div_stage_type nx;
      logic [DIV_W-1:0] dsh;
      always_comb begin
         nx  = dv_ff[k];
         dsh = dv_ff[k].den << SH;
         if (dv_ff[k].rem_u >= dsh) begin
            nx.rem_u = dv_ff[k].rem_u - dsh;
            nx.q_u[SH] = 1'b1;
         end
         if (dv_ff[k].rem_v >= dsh) begin
            nx.rem_v = dv_ff[k].rem_v - dsh;
            nx.q_v[SH] = 1'b1;
         end
      end
      always_ff @(posedge clock) begin
         if (reset) dv_ff[k+1].valid <= 1'b0;
         else if (advance) dv_ff[k+1] <= nx;
      end
   end

   // output stage
   div_stage_type   fin;
   logic [QUO_W:0]  dc, dr;
   logic            outside;
   logic [39:0]     tdata_in, tdata_ff;
   logic [STAT_W-1:0] stat_in, stat_ff;

   always_comb begin
      fin = dv_ff[NSTG];
      dc  = (fin.cls_u == CLS_POS) ? {1'b0, fin.q_u} + 1'b1 : '0;
      dr  = (fin.cls_v == CLS_POS) ? {1'b0, fin.q_v} + 1'b1 : '0;
      outside = (fin.cls_u == CLS_BAD) || (fin.cls_v == CLS_BAD) ||
                (dc >= PAD_W_Q) || (dr >= PAD_H_Q);
      tdata_in = '0;
      tdata_in[38:31] = fin.pix;
      if (fin.bad_scale) begin
         stat_in = ST_SCALE;
      end else if (outside) begin
         stat_in = ST_OUTSIDE;
      end else begin
         stat_in = ST_WRITE;
         tdata_in[7:0]   = dc[QUO_W-1:0];
         tdata_in[15:8]  = dr[QUO_W-1:0];
         tdata_in[30:16] = IDX_W'(IDX_W'(dr) * PAD_W_I + IDX_W'(dc));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) dv_out_valid_ff <= 1'b0;
      else if (advance) dv_out_valid_ff <= fin.valid;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         tdata_ff <= tdata_in;
         stat_ff  <= stat_in;
      end
   end

   assign rsp_tdata = tdata_ff;
   assign rsp_tuser = stat_ff;

endmodule
